// ----- design/cgc_pkg.sv -----
// ----------------------------------------------------------------------------
// cgc_pkg
// shared types and codes for the click gesture classifier
// ----------------------------------------------------------------------------
`default_nettype none

package cgc_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 8;
  localparam int TICKS_WIDTH         = 8;
  localparam logic [TICKS_WIDTH-1:0] WINDOW_TICKS_RESET = 8'd6;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_PRESSED  = 3'd1;
  localparam logic [2:0] PH_RELEASED = 3'd2;
  localparam logic [2:0] PH_DOUBLE   = 3'd3;
  localparam logic [2:0] PH_HOLD     = 3'd4;

  localparam logic [1:0] G_NONE   = 2'd0;
  localparam logic [1:0] G_SINGLE = 2'd1;
  localparam logic [1:0] G_DOUBLE = 2'd2;
  localparam logic [1:0] G_HOLD   = 2'd3;

  localparam logic LVL_PRESSED  = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

  typedef struct packed {
    logic [1:0] gesture;
    logic [2:0] phase;
  } result_t;

endpackage

`default_nettype wire

// ----- design/cgc_fsm.sv -----
// ----------------------------------------------------------------------------
// cgc_fsm
// gesture state machine: phase, previous level and window counter
// ----------------------------------------------------------------------------
`default_nettype none

module cgc_fsm #(
  parameter int COUNT_WIDTH = cgc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              step,
  input  wire                              level,
  input  wire [cgc_pkg::TICKS_WIDTH-1:0]   window_len,
  output cgc_pkg::result_t                 result
);

  localparam int WIDE = (COUNT_WIDTH > cgc_pkg::TICKS_WIDTH) ? COUNT_WIDTH
                                                               : cgc_pkg::TICKS_WIDTH;

  logic [2:0]             phase;
  logic [2:0]             phase_next;
  logic                   prev_level;
  logic                   prev_level_next;
  logic [COUNT_WIDTH-1:0] window_left;
  logic [COUNT_WIDTH-1:0] window_left_next;
  logic [WIDE-1:0]        len_wide;
  logic [COUNT_WIDTH-1:0] window_load;
  logic [COUNT_WIDTH-1:0] window_dec;
  logic                   expired;
  logic                   press_edge;
  logic                   release_edge;
  logic [1:0]             gesture;

  assign len_wide     = WIDE'(window_len);
  assign window_load  = len_wide[COUNT_WIDTH-1:0];
  assign window_dec   = (window_left != '0) ? window_left - COUNT_WIDTH'(1) : '0;
  assign expired      = (window_dec == '0);
  assign press_edge   = (level == cgc_pkg::LVL_PRESSED) &&
                        (prev_level == cgc_pkg::LVL_RELEASED);
  assign release_edge = (level == cgc_pkg::LVL_RELEASED) &&
                        (prev_level == cgc_pkg::LVL_PRESSED);

  always_comb begin
    phase_next       = phase;
    prev_level_next  = prev_level;
    window_left_next = window_left;
    gesture          = cgc_pkg::G_NONE;
    case (phase)
      cgc_pkg::PH_IDLE: begin
        if (press_edge) begin
          phase_next       = cgc_pkg::PH_PRESSED;
          window_left_next = window_load;
        end
        prev_level_next = level;
      end
      cgc_pkg::PH_PRESSED: begin
        if (release_edge) begin
          phase_next       = cgc_pkg::PH_RELEASED;
          window_left_next = window_load;
        end else begin
          window_left_next = window_dec;
          if (expired && level == cgc_pkg::LVL_PRESSED &&
              prev_level == cgc_pkg::LVL_PRESSED) begin
            phase_next = cgc_pkg::PH_HOLD;
          end
        end
        prev_level_next = level;
      end
      cgc_pkg::PH_RELEASED: begin
        if (press_edge) begin
          phase_next      = cgc_pkg::PH_DOUBLE;
          prev_level_next = level;
        end else begin
          window_left_next = window_dec;
          if (expired && level == cgc_pkg::LVL_RELEASED) begin
            gesture         = cgc_pkg::G_SINGLE;
            phase_next      = cgc_pkg::PH_IDLE;
            prev_level_next = level;
          end
        end
      end
      cgc_pkg::PH_DOUBLE: begin
        gesture    = cgc_pkg::G_DOUBLE;
        phase_next = cgc_pkg::PH_IDLE;
      end
      cgc_pkg::PH_HOLD: begin
        if (release_edge) begin
          gesture    = cgc_pkg::G_HOLD;
          phase_next = cgc_pkg::PH_IDLE;
        end
        prev_level_next = level;
      end
      default: begin
        phase_next = cgc_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= cgc_pkg::PH_IDLE;
      prev_level  <= cgc_pkg::LVL_RELEASED;
      window_left <= '0;
    end else if (step) begin
      phase       <= phase_next;
      prev_level  <= prev_level_next;
      window_left <= window_left_next;
    end
  end

  assign result.gesture = gesture;
  assign result.phase   = phase_next;

endmodule

`default_nettype wire

// ----- design/cgc_out_reg.sv -----
// ----------------------------------------------------------------------------
// cgc_out_reg
// result register on the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module cgc_out_reg (
  input  wire               clk,
  input  wire               rst,
  input  wire               load,
  input  cgc_pkg::result_t  load_data,
  output logic              can_load,
  output logic              out_valid,
  input  wire               out_ready,
  output cgc_pkg::result_t  out_data
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      out_data <= load_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/click_gesture_classifier.sv -----
// ----------------------------------------------------------------------------
// click_gesture_classifier
// single, double click and hold detector on a sampled active-low button
// ----------------------------------------------------------------------------
// input channel: one button_level word per sample tick (0 pressed, 1 released)
// on in_valid / in_ready. output channel: one gesture and phase word for every
// input word on out_valid / out_ready, in order.
// config channel: window_ticks on cfg_valid / cfg_ready sets the click window
// length in sample ticks; cfg_ready is always high, write only while idle.
// path from input accept to output valid: the input register, then the state
// machine step into the result register.
// throughput: one word per cycle while out_ready stays high; the input register
// and the result register each move whenever the stage after them is free.
// receiver stall: the result register holds, the input register fills and then
// in_ready drops; no word is lost or repeated.
// reset: synchronous, active high; phase idle, previous level released, window
// counter zero, window length 6 ticks, both pipeline registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module click_gesture_classifier #(
  parameter int COUNT_WIDTH = cgc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             button_level,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [1:0]                      gesture,
  output logic [2:0]                      phase,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [cgc_pkg::TICKS_WIDTH-1:0]  window_ticks
);

  logic                            in_full;
  logic                            level;
  logic                            can_load;
  logic                            step;
  logic [cgc_pkg::TICKS_WIDTH-1:0] window_len;
  cgc_pkg::result_t                step_result;
  cgc_pkg::result_t                out_data;

  assign cfg_ready = 1'b1;
  assign step      = in_full && can_load;
  assign in_ready  = !in_full || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= cgc_pkg::WINDOW_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_len <= window_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      level <= button_level;
    end
  end

  cgc_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .level      (level),
    .window_len (window_len),
    .result     (step_result)
  );

  cgc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_full),
    .load_data (step_result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign gesture = out_data.gesture;
  assign phase   = out_data.phase;

endmodule

`default_nettype wire

// ----- test/tb_click_gesture_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_click_gesture_classifier
// self-checking bench for the click gesture classifier
// ----------------------------------------------------------------------------
// button level words are queued by the stimulus process and sent by a clocked
// driver with random gaps; a clocked monitor stalls the result channel at
// random, predicts gesture and phase for every accepted word from its own copy
// of the state machine and compares each result word with the oldest
// prediction. the window length is rewritten between phases while idle,
// including zero, one and the 8-bit maximum of 255.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_click_gesture_classifier;

  localparam int TW = cgc_pkg::TICKS_WIDTH;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          button_level = cgc_pkg::LVL_RELEASED;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [1:0]    gesture;
  logic [2:0]    phase;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [TW-1:0] window_ticks = cgc_pkg::WINDOW_TICKS_RESET;

  click_gesture_classifier uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .button_level (button_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .gesture      (gesture),
    .phase        (phase),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .window_ticks (window_ticks)
  );

  always #1 clk = ~clk;

  logic             level_queue[$];
  cgc_pkg::result_t expected_results[$];
  int unsigned      words_queued = 0;
  int unsigned      mismatch_count = 0;
  logic             steady = 1'b0;
  int unsigned      send_gap = 0;
  int unsigned      stall_left = 0;

  // own copy of the classifier state
  logic [TW-1:0] model_window;
  logic [2:0]    model_phase;
  logic          model_prev;
  logic [7:0]    model_left;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic window_over();
    if (model_left != 0) model_left = model_left - 1'b1;
    return model_left == 0;
  endfunction

  function automatic cgc_pkg::result_t classify(logic lvl);
    cgc_pkg::result_t r;
    r.gesture = cgc_pkg::G_NONE;
    case (model_phase)
      cgc_pkg::PH_IDLE: begin
        if (lvl == cgc_pkg::LVL_PRESSED && model_prev == cgc_pkg::LVL_RELEASED) begin
          model_phase = cgc_pkg::PH_PRESSED;
          model_left  = model_window;
        end
        model_prev = lvl;
      end
      cgc_pkg::PH_PRESSED: begin
        if (lvl == cgc_pkg::LVL_RELEASED && model_prev == cgc_pkg::LVL_PRESSED) begin
          model_phase = cgc_pkg::PH_RELEASED;
          model_left  = model_window;
        end else if (window_over()) begin
          if (lvl == cgc_pkg::LVL_PRESSED && model_prev == cgc_pkg::LVL_PRESSED)
            model_phase = cgc_pkg::PH_HOLD;
        end
        model_prev = lvl;
      end
      cgc_pkg::PH_RELEASED: begin
        if (lvl == cgc_pkg::LVL_PRESSED && model_prev == cgc_pkg::LVL_RELEASED) begin
          model_phase = cgc_pkg::PH_DOUBLE;
          model_prev  = lvl;
        end else if (window_over() && lvl == cgc_pkg::LVL_RELEASED) begin
          r.gesture   = cgc_pkg::G_SINGLE;
          model_phase = cgc_pkg::PH_IDLE;
          model_prev  = lvl;
        end
      end
      cgc_pkg::PH_DOUBLE: begin
        r.gesture   = cgc_pkg::G_DOUBLE;
        model_phase = cgc_pkg::PH_IDLE;
      end
      cgc_pkg::PH_HOLD: begin
        if (lvl == cgc_pkg::LVL_RELEASED && model_prev == cgc_pkg::LVL_PRESSED) begin
          r.gesture   = cgc_pkg::G_HOLD;
          model_phase = cgc_pkg::PH_IDLE;
        end
        model_prev = lvl;
      end
      default: model_phase = cgc_pkg::PH_IDLE;
    endcase
    r.phase = model_phase;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (level_queue.size() != 0) begin
        in_valid     <= 1'b1;
        button_level <= level_queue.pop_front();
        send_gap     <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cgc_pkg::result_t want;
    if (rst) begin
      out_ready    <= 1'b0;
      stall_left   <= 0;
      model_window = cgc_pkg::WINDOW_TICKS_RESET;
      model_phase  = cgc_pkg::PH_IDLE;
      model_prev   = cgc_pkg::LVL_RELEASED;
      model_left   = '0;
    end else begin
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left <= pick_gap();
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result word: gesture %0d phase %0d", gesture, phase);
        end else begin
          want = expected_results.pop_front();
          if (gesture !== want.gesture || phase !== want.phase) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected gesture %0d phase %0d, got gesture %0d phase %0d",
                       want.gesture, want.phase, gesture, phase);
          end
        end
      end
      if (cfg_valid && cfg_ready) model_window = window_ticks;
      if (in_valid && in_ready) expected_results.push_back(classify(button_level));
    end
  end

  task automatic push_run(logic lvl, int unsigned n);
    repeat (n) begin
      level_queue.push_back(lvl);
      words_queued++;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (level_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(logic [TW-1:0] v);
    @(posedge clk);
    cfg_valid    <= 1'b1;
    window_ticks <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_gesture(int unsigned w);
    int unsigned weff;
    int unsigned kind;
    weff = (w == 0) ? 1 : w;
    kind = $urandom_range(0, 9);
    push_run(cgc_pkg::LVL_RELEASED, $urandom_range(1, 3));
    case (kind)
      0, 1: begin
        push_run(cgc_pkg::LVL_PRESSED, $urandom_range(1, weff));
        push_run(cgc_pkg::LVL_RELEASED, weff + $urandom_range(1, 3));
      end
      2, 3: begin
        push_run(cgc_pkg::LVL_PRESSED, $urandom_range(1, weff));
        push_run(cgc_pkg::LVL_RELEASED, $urandom_range(1, weff));
        push_run(cgc_pkg::LVL_PRESSED, $urandom_range(1, 3));
        push_run(cgc_pkg::LVL_RELEASED, $urandom_range(1, 3));
      end
      4, 5: begin
        push_run(cgc_pkg::LVL_PRESSED, weff + $urandom_range(1, 3));
        push_run(cgc_pkg::LVL_RELEASED, $urandom_range(1, 3));
      end
      6, 7: begin
        push_run(cgc_pkg::LVL_PRESSED, $urandom_range(1, weff + 2));
        push_run(cgc_pkg::LVL_RELEASED, $urandom_range(1, weff + 2));
        push_run(cgc_pkg::LVL_PRESSED, $urandom_range(0, 2));
      end
      default: begin
        repeat ($urandom_range(1, 8)) push_run(logic'($urandom_range(0, 1)), 1);
      end
    endcase
  endtask

  task automatic random_phase(logic [TW-1:0] w, int unsigned budget);
    int unsigned start;
    steady <= ($urandom_range(0, 3) == 0);
    write_window(w);
    start = words_queued;
    while (words_queued - start < budget) add_gesture(w);
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // single click with the reset window length
    push_run(cgc_pkg::LVL_PRESSED, 1);
    push_run(cgc_pkg::LVL_RELEASED, 7);
    wait_idle();

    write_window(8'd2);
    // press held to the last tick of the first window becomes a hold, reported on release
    push_run(cgc_pkg::LVL_PRESSED, 3);
    push_run(cgc_pkg::LVL_RELEASED, 3);
    // double click, the word after the second press is ignored
    push_run(cgc_pkg::LVL_PRESSED, 1);
    push_run(cgc_pkg::LVL_RELEASED, 1);
    push_run(cgc_pkg::LVL_PRESSED, 2);
    push_run(cgc_pkg::LVL_RELEASED, 1);
    // held past the window, reported on release
    push_run(cgc_pkg::LVL_PRESSED, 4);
    push_run(cgc_pkg::LVL_RELEASED, 1);
    wait_idle();

    random_phase(8'd0, 60);
    random_phase(8'd1, 80);
    random_phase(8'd255, 1);
    random_phase(8'd6, 100);
    repeat (4) random_phase(TW'($urandom_range(1, 20)), 60);
    random_phase(8'd128, 20);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
